// ===== hw/rtl/first_fit_free_list_allocator_macros.svh =====
// assertion helpers shared by the checker
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
// same-cycle implication, held off while reset is low
`define FFA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, held off while reset is low
`define FFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/ffa_pkg.sv =====
package ffa_pkg;

    localparam int unsigned SizeW = 24;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_ZERO_SIZE  = 3'd1;
    localparam t_status ST_NO_MEMORY  = 3'd2;
    localparam t_status ST_DBL_FREE   = 3'd3;
    localparam t_status ST_BAD_HANDLE = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_UNLINK,
        S_BUMP,
        S_FREE,
        S_EMIT
    } t_state;

    // one finished result before it moves to the output register
    typedef struct packed {
        t_status          status;
        logic [SizeW-1:0] offset;
        logic [7:0]       handle;
        logic [SizeW-1:0] size;
        logic             reused;
    } t_result;

endpackage

// ===== hw/rtl/ffa_ram.sv =====
module ffa_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 58
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/first_fit_free_list_allocator.sv =====
// First-fit heap allocator. Each word on the slave side is one request: tuser
// selects allocate (0) or free (1). The block table (payload size, header
// offset, busy flag, free-list link) lives in one synchronous RAM with a
// registered read port; every table access goes through it. A free reads the
// entry and, if it is busy, pushes it on the free-list head. An allocate
// walks the free list and claims the first entry that fits, rewriting the
// predecessor link when that entry is not the head; if none fits, it falls
// through to the bump path. The walk reads one list entry per cycle from the
// table RAM. Zero-size requests and bad handles go straight to the result.
// One request is in flight at a time; a finished result sits in an output
// register, so the next request is taken while the previous result still
// waits for m_axis_tready.
// ALIGN_BYTES must be a power of two. There is no clearing pass: entry data is
// only used after it was written.
module first_fit_free_list_allocator #(
    parameter int unsigned MAX_BLOCKS   = 256,
    parameter int unsigned ALIGN_BYTES  = 16,
    parameter int unsigned HDR_BYTES    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: heap_limit
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [23:0] request_size, [31:24] block_handle
    input  logic        s_axis_tuser,  // opcode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [23:0] payload_offset, [31:24] granted_handle, [55:32] granted_size,
    // [56] reused, [63:57] zero
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser   // status
);

    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = IW + 1;               // index plus null marker
    localparam int unsigned EW = 2 * ffa_pkg::SizeW + 1 + CW;
    localparam logic [CW-1:0] NULL_IDX = CW'(MAX_BLOCKS);
    localparam logic [24:0]   AMASK    = 25'(ALIGN_BYTES - 1);
    localparam logic [25:0]   HDR      = 26'(HDR_BYTES);

    // table entry layout: {next, busy, start, size}
    localparam int unsigned E_START = 24;
    localparam int unsigned E_BUSY  = 48;
    localparam int unsigned E_NEXT  = 49;

    ffa_pkg::t_state  r_state, n_state;
    logic [23:0]      r_limit;
    logic [CW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [24:0]      r_used, n_used;
    logic [24:0]      r_need, n_need;
    logic [CW-1:0]    r_cur, n_cur;
    logic [CW-1:0]    r_prev, n_prev;
    logic [CW-1:0]    r_steps, n_steps;
    logic [EW-1:0]    r_prev_ent, n_prev_ent;
    logic [CW-1:0]    r_link, n_link;
    logic [IW-1:0]    r_handle, n_handle;
    ffa_pkg::t_result r_res, n_res;
    logic             r_ovalid, n_ovalid;
    ffa_pkg::t_result r_out, n_out;

    // ram port
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    logic          in_acc;
    logic [24:0]   req_need;
    logic [25:0]   bump_total;
    logic [CW-1:0] ent_next;
    logic [23:0]   ent_size, ent_start;
    logic          ent_busy;
    logic          fits;

    ffa_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(EW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    // round up to the alignment
    assign req_need   = ({1'b0, s_axis_tdata[23:0]} + AMASK) & ~AMASK;
    assign bump_total = {1'b0, r_used} + HDR + {1'b0, r_need};
    assign ent_size   = mem_rdata[23:0];
    assign ent_start  = mem_rdata[E_START +: 24];
    assign ent_busy   = mem_rdata[E_BUSY];
    assign ent_next   = mem_rdata[E_NEXT +: CW];
    assign fits       = {1'b0, ent_size} >= r_need;

    // next state and datapath
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_used     = r_used;
        n_need     = r_need;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_steps    = r_steps;
        n_prev_ent = r_prev_ent;
        n_link     = r_link;
        n_handle   = r_handle;
        n_res      = r_res;
        n_ovalid   = r_ovalid;
        n_out      = r_out;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ffa_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                    if (s_axis_tuser == ffa_pkg::OP_ALLOC) begin
                        n_need = req_need;
                        if (s_axis_tdata[23:0] == '0) begin
                            n_res.status = ffa_pkg::ST_ZERO_SIZE;
                            n_state      = ffa_pkg::S_EMIT;
                        end else if (r_head != NULL_IDX) begin
                            n_cur   = r_head;
                            n_prev  = NULL_IDX;
                            n_steps = '0;
                            n_state = ffa_pkg::S_WALK;
                        end else begin
                            n_state = ffa_pkg::S_BUMP;
                        end
                    end else begin
                        n_handle = IW'(s_axis_tdata[31:24]);
                        if (32'(s_axis_tdata[31:24]) >= 32'(r_count)) begin
                            n_res.status = ffa_pkg::ST_BAD_HANDLE;
                            n_state      = ffa_pkg::S_EMIT;
                        end else begin
                            n_state = ffa_pkg::S_FREE;
                        end
                    end
                end
            end
            ffa_pkg::S_WALK: begin
                if (fits) begin
                    n_res.status = ffa_pkg::ST_OK;
                    n_res.offset = 24'({1'b0, ent_start} + HDR);
                    n_res.handle = 8'(r_cur);
                    n_res.size   = ent_size;
                    n_res.reused = 1'b1;
                    n_link       = ent_next;
                    if (r_prev == NULL_IDX) begin
                        n_head  = ent_next;
                        n_state = ffa_pkg::S_EMIT;
                    end else begin
                        n_state = ffa_pkg::S_UNLINK;
                    end
                end else begin
                    n_prev     = r_cur;
                    n_prev_ent = mem_rdata;
                    n_cur      = ent_next;
                    n_steps    = r_steps + 1'b1;
                    if (ent_next < NULL_IDX && 32'(r_steps) + 1 < 32'(MAX_BLOCKS)) begin
                        n_state = ffa_pkg::S_WALK;
                    end else begin
                        n_state = ffa_pkg::S_BUMP;
                    end
                end
            end
            ffa_pkg::S_UNLINK: begin
                n_state = ffa_pkg::S_EMIT;
            end
            ffa_pkg::S_BUMP: begin
                if (r_count >= NULL_IDX || bump_total > {2'b0, r_limit}) begin
                    n_res.status = ffa_pkg::ST_NO_MEMORY;
                end else begin
                    n_res.status = ffa_pkg::ST_OK;
                    n_res.offset = 24'({1'b0, r_used} + HDR);
                    n_res.handle = 8'(r_count);
                    n_res.size   = r_need[23:0];
                    n_res.reused = 1'b0;
                    n_count      = r_count + 1'b1;
                    n_used       = bump_total[24:0];
                end
                n_state = ffa_pkg::S_EMIT;
            end
            ffa_pkg::S_FREE: begin
                if (!ent_busy) begin
                    n_res.status = ffa_pkg::ST_DBL_FREE;
                end else begin
                    n_res.status = ffa_pkg::ST_OK;
                    n_head       = CW'(r_handle);
                end
                n_state = ffa_pkg::S_EMIT;
            end
            ffa_pkg::S_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = ffa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffa_pkg::S_IDLE;
            end
        endcase
    end

    // ram access and handshake outputs
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        case (r_state)
            ffa_pkg::S_IDLE: begin
                if (in_acc && s_axis_tuser == ffa_pkg::OP_ALLOC) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_head[IW-1:0];
                end else if (in_acc) begin
                    mem_re    = 1'b1;
                    mem_raddr = IW'(s_axis_tdata[31:24]);
                end
            end
            ffa_pkg::S_WALK: begin
                if (fits) begin
                    // claim the block, keep the rest of its entry
                    mem_we    = 1'b1;
                    mem_waddr = r_cur[IW-1:0];
                    mem_wdata = mem_rdata;
                    mem_wdata[E_BUSY] = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = ent_next[IW-1:0];
                end
            end
            ffa_pkg::S_UNLINK: begin
                // predecessor now skips the taken block
                mem_we    = 1'b1;
                mem_waddr = r_prev[IW-1:0];
                mem_wdata = r_prev_ent;
                mem_wdata[E_NEXT +: CW] = r_link;
            end
            ffa_pkg::S_BUMP: begin
                if (!(r_count >= NULL_IDX || bump_total > {2'b0, r_limit})) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_count[IW-1:0];
                    mem_wdata = {NULL_IDX, 1'b1, r_used[23:0], r_need[23:0]};
                end
            end
            ffa_pkg::S_FREE: begin
                if (ent_busy) begin
                    // push on the list head
                    mem_we    = 1'b1;
                    mem_waddr = r_handle;
                    mem_wdata = {r_head, 1'b0, ent_start, ent_size};
                end
            end
            default: begin
            end
        endcase
    end

    // no word is taken while reset is applied
    assign s_axis_tready = (r_state == ffa_pkg::S_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {7'd0, r_out.reused, r_out.size, r_out.handle, r_out.offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffa_pkg::S_IDLE;
            r_limit  <= 24'd1024;
            r_head   <= NULL_IDX;
            r_count  <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_need     <= n_need;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_steps    <= n_steps;
        r_prev_ent <= n_prev_ent;
        r_link     <= n_link;
        r_handle   <= n_handle;
        r_res      <= n_res;
        r_out      <= n_out;
    end

endmodule

// ===== hw/rtl/ffa_checker.sv =====
`include "first_fit_free_list_allocator_macros.svh"

module ffa_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    `FFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `FFA_ASSERT_NOW(a_status_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser <= ffa_pkg::ST_BAD_HANDLE)
    `FFA_ASSERT_NOW(a_fail_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != ffa_pkg::ST_OK, m_axis_tdata == 64'd0)
    `FFA_ASSERT_NOW(a_reuse_size, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[56], m_axis_tdata[55:32] != 24'd0)

endmodule

bind first_fit_free_list_allocator ffa_props u_ffa_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
